@@ rtl/sct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_pkg: shared constants, types and table builder for the sine/cosine
// table interpolator.
// The sine table is split into an even bank and an odd bank. A neighboring
// pair of entries then always falls into different banks.
// ----------------------------------------------------------------------------
package sct_pkg;

  // Table geometry and sample format.
  localparam int LUT_DEPTH    = 256;
  localparam int SAMPLE_WIDTH = 16;
  localparam int IDX_W        = $clog2(LUT_DEPTH);
  localparam int HALF_SIZE    = LUT_DEPTH / 2;
  localparam int BANK_W       = IDX_W - 1;
  localparam int FRAC_W       = 16;
  localparam int ANGLE_W      = 32;
  localparam int TURN_W       = 32;

  // round(2^32 / (2*pi)) turns a Q16.16 angle into a 32-bit turn fraction.
  localparam logic [31:0] RECIP_2PI_Q32 = 32'd683565276;

  // Peak sample value, 2^(SAMPLE_WIDTH-1) - 1.
  localparam int AMPLITUDE = (1 << (SAMPLE_WIDTH - 1)) - 1;

  localparam real PI_HALF = 1.57079632679489661923;

  // Angle of one quarter-turn step in the first quadrant.
  localparam real ANGLE_STEP = PI_HALF / LUT_DEPTH;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic        [BANK_W-1:0]       bank_addr_t;
  typedef sample_t bank_t [HALF_SIZE];

  // One table sample: round(AMPLITUDE * sin(2*pi*i/LUT_DEPTH)), half away
  // from zero. The angle is folded into the first quadrant first, so the
  // table is exactly symmetric.
  function automatic sample_t sine_sample(input int unsigned i);
    int unsigned four;
    int unsigned quad;
    int unsigned r;
    real         x;
    real         v;
    int          mag;
    sample_t     mag_s;
    four = 4 * i;
    quad = four >> IDX_W;
    r    = four - quad * LUT_DEPTH;
    if (quad[0]) begin
      r = LUT_DEPTH - r;
    end
    x   = ANGLE_STEP * real'(r);
    v   = real'(AMPLITUDE) * $sin(x) + 0.5;
    mag = $rtoi(v);
    if (mag > AMPLITUDE) begin
      mag = AMPLITUDE;
    end
    mag_s = sample_t'(mag);
    return (quad >= 2) ? -mag_s : mag_s;
  endfunction

  // Build one bank: odd_sel = 0 gives the even entries, 1 the odd ones.
  function automatic bank_t build_bank(input int unsigned odd_sel);
    bank_t bank;
    for (int j = 0; j < HALF_SIZE; j++) begin
      bank[j] = sine_sample(2 * j + odd_sel);
    end
    return bank;
  endfunction

endpackage
`default_nettype wire

@@ rtl/sincos_table_interpolator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sincos_table_interpolator: sine and cosine by table lookup with linear
// interpolation.
//
//   Channel   Ports                            Direction  Handshake
//   request   start, busy, in_angle            in         start high, busy low
//   result    out_valid, out_sine, out_cosine  out        one-cycle strobe
//
// One request may be accepted in every cycle while busy is low; results
// appear in request order.
// The pipeline is angle register, turn multiplier, banked ROM read,
// interpolation multiplier, output add.
// The two sine banks are dual-port ROMs with a registered read, so the
// sine pair and the cosine pair are fetched in the same cycle.
// Reset holds busy high; the register clears in the cycle after rst_n rises.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module sincos_table_interpolator (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [sct_pkg::ANGLE_W-1:0]    in_angle,
  output logic                                       out_valid,
  output logic signed [sct_pkg::SAMPLE_WIDTH-1:0]    out_sine,
  output logic signed [sct_pkg::SAMPLE_WIDTH-1:0]    out_cosine
);

  localparam int SW = sct_pkg::SAMPLE_WIDTH;
  localparam int PW = SW + 1 + sct_pkg::FRAC_W + 1;

  // Bank contents, fixed at build time.
  localparam sct_pkg::bank_t EVEN_ROM = sct_pkg::build_bank(0);
  localparam sct_pkg::bank_t ODD_ROM  = sct_pkg::build_bank(1);

  // Cosine sits a quarter table ahead, which is LUT_DEPTH/8 entries in a bank.
  localparam sct_pkg::bank_addr_t QTR_BANK =
    sct_pkg::bank_addr_t'(sct_pkg::LUT_DEPTH / 8);

  logic        busy_r;
  logic        acc;
  logic [4:1]  vld_r;

  logic signed [sct_pkg::ANGLE_W-1:0] angle_r;
  logic signed [63:0]                 prod;
  logic [sct_pkg::TURN_W-1:0]         turn_r;

  logic [sct_pkg::IDX_W-1:0]  idx;
  logic                       odd_idx;
  sct_pkg::bank_addr_t        m_s;
  sct_pkg::bank_addr_t        m_c;
  logic [sct_pkg::FRAC_W-1:0] frac;

  sct_pkg::sample_t           ev_s_r, od_s_r, ev_c_r, od_c_r;
  logic                       odd_r;
  logic [sct_pkg::FRAC_W-1:0] frac_r;

  sct_pkg::sample_t        y0_s, y1_s, y0_c, y1_c;
  logic signed [SW:0]      d_s, d_c;
  logic signed [PW-1:0]    p_s, p_c;
  logic signed [PW-1:0]    p_s_r, p_c_r;
  sct_pkg::sample_t        y0_s_r, y0_c_r;

  logic signed [PW-1:0]    q_s, q_c;

  // Busy only covers reset; the pipeline itself never stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign acc  = start && !busy_r;

  // Valid bits that travel with each request down the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      vld_r     <= {vld_r[3:1], acc};
      out_valid <= vld_r[4];
    end
  end

  // Stage 1: capture the angle.
  always_ff @(posedge clk) begin
    if (acc) begin
      angle_r <= in_angle;
    end
  end

  // Stage 2: scale to a turn fraction; the wrap of the product reduces
  // any angle, negative ones included, to one turn.
  assign prod = angle_r * $signed({1'b0, sct_pkg::RECIP_2PI_Q32});

  always_ff @(posedge clk) begin
    turn_r <= prod[47:16];
  end

  // Stage 3: split the turn into index and fraction and read both banks.
  // Entries idx and idx+1 always sit in opposite banks.
  assign idx     = turn_r[sct_pkg::TURN_W-1 -: sct_pkg::IDX_W];
  assign frac    = turn_r[sct_pkg::TURN_W-1-sct_pkg::IDX_W -: sct_pkg::FRAC_W];
  assign odd_idx = idx[0];
  assign m_s     = idx[sct_pkg::IDX_W-1:1];
  assign m_c     = m_s + QTR_BANK;

  always_ff @(posedge clk) begin
    ev_s_r <= EVEN_ROM[m_s + sct_pkg::bank_addr_t'(odd_idx)];
    od_s_r <= ODD_ROM[m_s];
    ev_c_r <= EVEN_ROM[m_c + sct_pkg::bank_addr_t'(odd_idx)];
    od_c_r <= ODD_ROM[m_c];
    odd_r  <= odd_idx;
    frac_r <= frac;
  end

  // Stage 4: order the pair, take the slope and scale by the fraction.
  assign y0_s = odd_r ? od_s_r : ev_s_r;
  assign y1_s = odd_r ? ev_s_r : od_s_r;
  assign y0_c = odd_r ? od_c_r : ev_c_r;
  assign y1_c = odd_r ? ev_c_r : od_c_r;

  assign d_s = {y1_s[SW-1], y1_s} - {y0_s[SW-1], y0_s};
  assign d_c = {y1_c[SW-1], y1_c} - {y0_c[SW-1], y0_c};
  assign p_s = d_s * $signed({1'b0, frac_r});
  assign p_c = d_c * $signed({1'b0, frac_r});

  always_ff @(posedge clk) begin
    p_s_r  <= p_s;
    p_c_r  <= p_c;
    y0_s_r <= y0_s;
    y0_c_r <= y0_c;
  end

  // Stage 5: floor the scaled slope and add the base sample.
  assign q_s = p_s_r >>> sct_pkg::FRAC_W;
  assign q_c = p_c_r >>> sct_pkg::FRAC_W;

  always_ff @(posedge clk) begin
    out_sine   <= y0_s_r + q_s[SW-1:0];
    out_cosine <= y0_c_r + q_c[SW-1:0];
  end

  // Every accepted request yields a result strobe.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##5 out_valid)
    else $error("request did not produce a result");

  // No result appears without an earlier accepted request.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, 5))
    else $error("result without a request");

  // Interpolated values stay within the table amplitude.
  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sine != {1'b1, {(SW-1){1'b0}}})
               && (out_cosine != {1'b1, {(SW-1){1'b0}}}))
    else $error("sample outside the amplitude range");

endmodule
`default_nettype wire

@@ verif/tb_sincos_table_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sincos_table_interpolator: self-checking testbench for the sine/cosine
// table interpolator.
// A queue of angles feeds a burst-and-gap driver. Every accepted request
// gets an expected sine/cosine pair from an exact integer predictor with its
// own copy of the sine table. Each result strobe is checked field by field
// against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_sincos_table_interpolator;

  localparam logic [63:0] PI_HALF_Q62  = 64'h6487ED5110B4611A;
  localparam int          NUM_RANDOM   = 2000;
  localparam int          TAIL_CYCLES  = 20;
  localparam int          MAX_REPORTS  = 10;
  localparam int          AW           = sct_pkg::ANGLE_W;
  localparam int          DEPTH        = sct_pkg::LUT_DEPTH;

  typedef struct {
    logic signed [AW-1:0] angle;
    sct_pkg::sample_t     sine;
    sct_pkg::sample_t     cosine;
  } sincos_t;

  logic                 clk      = 1'b0;
  logic                 rst_n    = 1'b0;
  logic                 start    = 1'b0;
  logic signed [AW-1:0] in_angle = '0;
  logic                 busy;
  logic                 out_valid;
  sct_pkg::sample_t     out_sine;
  sct_pkg::sample_t     out_cosine;

  // Predictor state: the sine table and the results still in flight.
  sct_pkg::sample_t     sine_lut [DEPTH];
  logic signed [AW-1:0] angle_queue [$];
  sincos_t              expected_sincos [$];

  int err_count     = 0;
  int request_count = 0;
  int result_count  = 0;
  int neg_count     = 0;
  int burst_left    = 1;
  int gap_left      = 0;

  sincos_table_interpolator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_angle   (in_angle),
    .out_valid  (out_valid),
    .out_sine   (out_sine),
    .out_cosine (out_cosine)
  );

  // Clock generation.
  initial begin
    forever #1 clk = ~clk;
  end

  // (a * b) >> 62 with the result kept to 64 bits.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Exact table sample: round(AMPLITUDE * sin(2*pi*i/DEPTH)), half away
  // from zero, computed from a Taylor series in Q62 fixed point.
  function automatic sct_pkg::sample_t exact_sine(input int unsigned i);
    logic [63:0] n;
    logic [63:0] four;
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] v;
    logic [63:0] k;
    logic [63:0] amp;
    bit          sub;
    n    = 64'(DEPTH);
    amp  = 64'(sct_pkg::AMPLITUDE);
    four = 64'd4 * 64'(i);
    quad = four / n;
    r    = four - quad * n;
    if (quad[0]) begin
      r = n - r;
    end
    x    = (PI_HALF_Q62 / n) * r + ((PI_HALF_Q62 % n) * r) / n;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    k    = 64'd1;
    sub  = 1'b1;
    while (term != 0 && k < 64'd80) begin
      term = mul_q62(term, x2) / ((k + 64'd1) * (k + 64'd2));
      k    = k + 64'd2;
      if (sub) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
      sub = ~sub;
    end
    hi = sum >> 31;
    lo = sum & 64'h7FFF_FFFF;
    v  = (hi * amp + (64'd1 << 30) + ((lo * amp) >> 31)) >> 31;
    if (v > amp) begin
      v = amp;
    end
    return (quad >= 64'd2) ? -sct_pkg::sample_t'(v) : sct_pkg::sample_t'(v);
  endfunction

  // Linear step between two samples, the product floored by 2^16.
  function automatic sct_pkg::sample_t lerp_sample(input sct_pkg::sample_t y0,
                                                   input sct_pkg::sample_t y1,
                                                   input logic [15:0] frac);
    longint a0;
    longint a1;
    longint d;
    a0 = y0;
    a1 = y1;
    d  = (a1 - a0) * longint'(frac);
    return sct_pkg::sample_t'(a0 + (d >>> 16));
  endfunction

  // Expected sine and cosine of one angle.
  function automatic sincos_t calc_sincos(input logic signed [AW-1:0] angle);
    logic signed [63:0] prod;
    logic [31:0]        turn;
    logic [63:0]        scaled;
    logic [15:0]        frac;
    int unsigned        idx;
    int unsigned        nxt;
    int unsigned        cidx;
    int unsigned        cnxt;
    sincos_t            res;
    prod   = $signed({{32{angle[AW-1]}}, angle})
             * $signed({32'd0, sct_pkg::RECIP_2PI_Q32});
    turn   = prod[47:16];
    scaled = {32'd0, turn} << sct_pkg::IDX_W;
    idx    = scaled[63:32] % DEPTH;
    frac   = scaled[31:16];
    nxt    = (idx + 1) % DEPTH;
    cidx   = (idx + DEPTH / 4) % DEPTH;
    cnxt   = (cidx + 1) % DEPTH;
    res.angle  = angle;
    res.sine   = lerp_sample(sine_lut[idx], sine_lut[nxt], frac);
    res.cosine = lerp_sample(sine_lut[cidx], sine_lut[cnxt], frac);
    return res;
  endfunction

  // Driver: requests go out in bursts of random length with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      start    <= 1'b0;
      in_angle <= $urandom;
    end else if (angle_queue.size() > 0) begin
      start    <= 1'b1;
      in_angle <= angle_queue[0];
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left = burst_left - 1;
      end
    end else begin
      start    <= 1'b0;
      in_angle <= $urandom;
    end
  end

  // Monitor: check each result strobe, then record an accepted request.
  always @(posedge clk) begin
    sincos_t exp_item;
    if (out_valid === 1'b1) begin
      result_count = result_count + 1;
      if (expected_sincos.size() == 0) begin
        err_count = err_count + 1;
        if (err_count <= MAX_REPORTS) begin
          $display("ERROR: result with nothing expected: sine=%0d cosine=%0d",
                   out_sine, out_cosine);
        end
      end else begin
        exp_item = expected_sincos.pop_front();
        if (out_sine !== exp_item.sine || out_cosine !== exp_item.cosine) begin
          err_count = err_count + 1;
          if (err_count <= MAX_REPORTS) begin
            $display("ERROR: angle=%0d sine exp=%0d got=%0d cosine exp=%0d got=%0d",
                     exp_item.angle, exp_item.sine, out_sine,
                     exp_item.cosine, out_cosine);
          end
        end
      end
    end
    if (rst_n && start === 1'b1 && busy === 1'b0) begin
      expected_sincos.push_back(calc_sincos(in_angle));
      void'(angle_queue.pop_front());
      request_count = request_count + 1;
      if (in_angle[AW-1]) begin
        neg_count = neg_count + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      sine_lut[i] = exact_sine(i);
    end

    // Zero, the smallest steps either way, and -1, which lands on the last
    // table entry and interpolates toward entry zero.
    angle_queue.push_back(32'sd0);
    angle_queue.push_back(32'sd1);
    angle_queue.push_back(-32'sd1);
    angle_queue.push_back(32'sd2);
    // Extremes of the angle field; the most negative one exercises the wrap.
    angle_queue.push_back(32'sh7FFF_FFFF);
    angle_queue.push_back(32'sh8000_0000);
    angle_queue.push_back(32'sh8000_0001);
    // Quarter, half, three-quarter and full turns; the cosine index wraps.
    angle_queue.push_back(32'sd102943);
    angle_queue.push_back(32'sd102944);
    angle_queue.push_back(32'sd205887);
    angle_queue.push_back(32'sd308831);
    angle_queue.push_back(32'sd411774);
    angle_queue.push_back(32'sd411775);
    angle_queue.push_back(32'sd411776);
    // Negative angles of the same sizes, and minus one radian.
    angle_queue.push_back(-32'sd102944);
    angle_queue.push_back(-32'sd205887);
    angle_queue.push_back(-32'sd411775);
    angle_queue.push_back(-32'sd65536);
    // Alternating and split bit patterns.
    angle_queue.push_back(32'sh5555_5555);
    angle_queue.push_back(32'shAAAA_AAAA);
    angle_queue.push_back(32'sh0000_FFFF);
    angle_queue.push_back(32'shFFFF_0000);
    angle_queue.push_back(32'sh0001_0000);

    // Random angles: full range, within a few turns, and close to zero.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          angle_queue.push_back($urandom);
        end
        6, 7, 8: begin
          angle_queue.push_back(int'($urandom_range(0, 1647100)) - 823550);
        end
        default: begin
          angle_queue.push_back(int'($urandom_range(0, 128)) - 64);
        end
      endcase
    end

    // Hold the synchronous reset, then release it on a falling clock edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all requests accepted and all results seen.
    while (angle_queue.size() > 0 || expected_sincos.size() > 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_sincos.size() != 0) begin
      err_count = err_count + expected_sincos.size();
    end

    $display("Summary: %0d angle requests (%0d negative) gave %0d sine/cosine results.",
             request_count, neg_count, result_count);
    $display("Summary: %0d mismatches or stray results counted.", err_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog on a run that never drains.
  initial begin
    #1000000;
    $display("Timeout: the run did not drain in time.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sincos_table_interpolator.f @@
rtl/sct_pkg.sv
rtl/sincos_table_interpolator.sv
verif/tb_sincos_table_interpolator.sv
